// ===== rtl/cvp_pkg.sv =====
`timescale 1ns / 1ps

package cvp_pkg;

    // widths fixed by the stream and register formats
    localparam int CELL_W      = 16;
    localparam int LEVEL_W     = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int S_DATA_W    = 24;
    localparam int M_DATA_W    = 8;
    localparam int VOLT_BITS_DEF = 16;

    localparam logic [LEVEL_W-1:0] OVER_EN_RST   = LEVEL_W'(4200);
    localparam logic [LEVEL_W-1:0] OVER_REL_RST  = LEVEL_W'(4100);
    localparam logic [LEVEL_W-1:0] UNDER_EN_RST  = LEVEL_W'(3000);
    localparam logic [LEVEL_W-1:0] UNDER_REL_RST = LEVEL_W'(3100);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OVER_EN   = 2'd0,
        CFG_OVER_REL  = 2'd1,
        CFG_UNDER_EN  = 2'd2,
        CFG_UNDER_REL = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [LEVEL_W-1:0] over_en;
        logic [LEVEL_W-1:0] over_rel;
        logic [LEVEL_W-1:0] under_en;
        logic [LEVEL_W-1:0] under_rel;
    } t_levels;

endpackage

// ===== rtl/cvp_minmax.sv =====
`timescale 1ns / 1ps

module cvp_minmax #(
    parameter int VOLT_BITS = cvp_pkg::VOLT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_has,
    input  logic                 i_last,
    input  logic [VOLT_BITS-1:0] i_volt,
    output logic [VOLT_BITS-1:0] o_frame_min,
    output logic [VOLT_BITS-1:0] o_frame_max
);

    logic [VOLT_BITS-1:0] r_min, n_min;
    logic [VOLT_BITS-1:0] r_max, n_max;

    always_comb begin
        n_min = (i_has && (i_volt < r_min)) ? i_volt : r_min;
        n_max = (i_has && (i_volt > r_max)) ? i_volt : r_max;
    end

    assign o_frame_min = n_min;
    assign o_frame_max = n_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= {VOLT_BITS{1'b1}};
            r_max <= '0;
        end else if (i_adv) begin
            // restore for the next frame once the last item is consumed
            if (i_last) begin
                r_min <= {VOLT_BITS{1'b1}};
                r_max <= '0;
            end else begin
                r_min <= n_min;
                r_max <= n_max;
            end
        end
    end

endmodule

// ===== rtl/cvp_eval.sv =====
`timescale 1ns / 1ps

module cvp_eval #(
    parameter int VOLT_BITS = cvp_pkg::VOLT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic                          i_pack,
    input  logic [VOLT_BITS-1:0]          i_min,
    input  logic [VOLT_BITS-1:0]          i_max,
    input  cvp_pkg::t_levels              i_lvl,
    input  logic                          i_m_tready,
    output logic                          o_m_tvalid,
    output logic [cvp_pkg::M_DATA_W-1:0]  o_m_tdata,
    output logic                          o_free
);

    localparam int CMP_W = (VOLT_BITS > cvp_pkg::LEVEL_W) ? VOLT_BITS : cvp_pkg::LEVEL_W;

    logic             r_over, r_under;
    logic             n_over, n_under;
    logic             r_out_valid;
    logic [3:0]       r_out_flags;
    logic [CMP_W-1:0] w_min, w_max;
    logic [CMP_W-1:0] w_oe, w_or, w_ue, w_ur;
    logic             w_bad;

    always_comb begin
        w_min = CMP_W'(i_min);
        w_max = CMP_W'(i_max);
        w_oe  = CMP_W'(i_lvl.over_en);
        w_or  = CMP_W'(i_lvl.over_rel);
        w_ue  = CMP_W'(i_lvl.under_en);
        w_ur  = CMP_W'(i_lvl.under_rel);
        w_bad = !i_pack || (i_min == {VOLT_BITS{1'b1}}) || (i_max == '0);
        if (w_bad) begin
            n_over  = 1'b1;
            n_under = 1'b1;
        end else begin
            // over sets above its enable level and clears only below both levels; under mirrors it
            n_over  = (w_max > w_oe) || (r_over && !((w_max < w_oe) && (w_max < w_or)));
            n_under = (w_min < w_ue) || (r_under && !((w_min > w_ue) && (w_min > w_ur)));
        end
    end

    assign o_free     = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(cvp_pkg::M_DATA_W - 4){1'b0}}, r_out_flags};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_over      <= 1'b0;
            r_under     <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_fire) begin
            r_over      <= n_over;
            r_under     <= n_under;
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_out_flags <= {!n_under, !n_over, n_under, n_over};
        end
    end

endmodule

// ===== rtl/cell_voltage_protection_unit.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Signals                                   Content
// s_axis    in   tvalid tready tdata[23:0] tuser tlast      one cell item per transfer
// m_axis    out  tvalid tready tdata[7:0]                   flags, one per frame
// cfg       in   i_cfg_valid o_cfg_ready i_cfg_index/data   threshold register write
//
// One item is accepted per cycle while s_axis_tready is high; it waits in the input
// register, and the frame result is loaded into the output register from the last item.
// Reset clears the flags, restores min/max and loads the default thresholds.
// A last item waits in the input register while a previous result is unread;
// only then does s_axis_tready drop. Config writes are always taken.
module cell_voltage_protection_unit #(
    parameter int VOLT_BITS = cvp_pkg::VOLT_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [0] pack_connected, [16:1] cell reading, [23:17] zero
    input  logic [cvp_pkg::S_DATA_W-1:0]       s_axis_tdata,
    // [0] has_cell
    input  logic                               s_axis_tuser,
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] over_voltage, [1] under_voltage, [2] charge_enable,
    // [3] discharge_enable, [7:4] zero
    output logic [cvp_pkg::M_DATA_W-1:0]       m_axis_tdata,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [cvp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [cvp_pkg::LEVEL_W-1:0]        i_cfg_data
);

    localparam int EXT_W = (VOLT_BITS > cvp_pkg::CELL_W) ? VOLT_BITS : cvp_pkg::CELL_W;

    cvp_pkg::t_levels     r_lvl;
    logic                 r_in_valid;
    logic                 r_in_pack;
    logic                 r_in_has;
    logic                 r_in_last;
    logic [VOLT_BITS-1:0] r_in_volt;
    logic                 w_accept, w_adv, w_free;
    logic [VOLT_BITS-1:0] w_volt, w_fmin, w_fmax;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl.over_en   <= cvp_pkg::OVER_EN_RST;
            r_lvl.over_rel  <= cvp_pkg::OVER_REL_RST;
            r_lvl.under_en  <= cvp_pkg::UNDER_EN_RST;
            r_lvl.under_rel <= cvp_pkg::UNDER_REL_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (cvp_pkg::t_cfg_idx'(i_cfg_index))
                cvp_pkg::CFG_OVER_EN:   r_lvl.over_en   <= i_cfg_data;
                cvp_pkg::CFG_OVER_REL:  r_lvl.over_rel  <= i_cfg_data;
                cvp_pkg::CFG_UNDER_EN:  r_lvl.under_en  <= i_cfg_data;
                cvp_pkg::CFG_UNDER_REL: r_lvl.under_rel <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // mask the reading to the tracked width
    assign w_volt = VOLT_BITS'(EXT_W'(s_axis_tdata[cvp_pkg::CELL_W:1]));

    // only a last item needs room in the output register
    assign w_adv         = r_in_valid && (!r_in_last || w_free);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_pack <= s_axis_tdata[0];
            r_in_has  <= s_axis_tuser;
            r_in_last <= s_axis_tlast;
            r_in_volt <= w_volt;
        end
    end

    cvp_minmax #(
        .VOLT_BITS (VOLT_BITS)
    ) u_minmax (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_has       (r_in_has),
        .i_last      (r_in_last),
        .i_volt      (r_in_volt),
        .o_frame_min (w_fmin),
        .o_frame_max (w_fmax)
    );

    cvp_eval #(
        .VOLT_BITS (VOLT_BITS)
    ) u_eval (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_adv && r_in_last),
        .i_pack     (r_in_pack),
        .i_min      (w_fmin),
        .i_max      (w_fmax),
        .i_lvl      (r_lvl),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata),
        .o_free     (w_free)
    );

`ifndef SYNTHESIS
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_in_last && m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a pending result");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_last) |=> m_axis_tvalid)
        else $error("frame end did not produce a result");

    a_enables_inverse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[2] != m_axis_tdata[0]) &&
                           (m_axis_tdata[3] != m_axis_tdata[1])))
        else $error("enable does not mirror its flag");
`endif

endmodule
